// ===== rtl/sqvg_pkg.sv =====
// Shared types, codes and arithmetic helpers of the sprite quad vertex generator.
// No dependencies; every other file of the block imports this package.
package sqvg_pkg;

    localparam int unsigned VERTEX_CAPACITY_DEF = 4096;
    localparam int unsigned QUEUE_DEPTH_DEF     = 4;
    localparam int unsigned VERTS_PER_SPRITE    = 6;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEX_PRESENT = 2'd0;
    localparam logic [1:0] CFG_RECIP_W     = 2'd1;
    localparam logic [1:0] CFG_RECIP_H     = 2'd2;

    // Request commands
    localparam logic CMD_SPRITE = 1'b0;
    localparam logic CMD_BEGIN  = 1'b1;

    // Flag bit positions
    localparam int unsigned FLAG_CENTERED = 0;
    localparam int unsigned FLAG_FLIP_H   = 1;
    localparam int unsigned FLAG_FLIP_V   = 2;
    localparam int unsigned FLAG_VISIBLE  = 3;

    // Quad corners
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BL = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_TR = 2'd3;

    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic        centered;
        logic        flip_h;
        logic        flip_v;
        logic [31:0] anchor_x;
        logic [31:0] anchor_y;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [15:0] scale_x;
        logic [15:0] scale_y;
        logic [15:0] src_x;
        logic [15:0] src_y;
        logic [15:0] src_w;
        logic [15:0] src_h;
        logic [31:0] tint;
        logic [15:0] slot;
    } t_sprite;

    typedef struct packed {
        logic [23:0] recip_w;
        logic [23:0] recip_h;
    } t_tex_cfg;

    typedef struct packed {
        logic [31:0] vert_x;
        logic [31:0] vert_y;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic [31:0] vert_color;
        logic [15:0] vertex_slot;
        logic        last;
    } t_vertex;

    // Triangle-list order: TL, BL, BR, TR, BR, TL
    function automatic logic [1:0] corner_of(input logic [2:0] step);
        logic [1:0] c;
        case (step)
            3'd0:    c = CORNER_TL;
            3'd1:    c = CORNER_BL;
            3'd2:    c = CORNER_BR;
            3'd3:    c = CORNER_TR;
            3'd4:    c = CORNER_BR;
            default: c = CORNER_TL;
        endcase
        return c;
    endfunction

    // Texel edge times Q0.24 reciprocal, truncated to Q0.16, saturated at 0xFFFF
    function automatic logic [15:0] tex_coord(input logic [16:0] texel,
                                              input logic [23:0] recip);
        logic [40:0] prod;
        logic [32:0] t;
        prod = 41'(texel) * 41'(recip);
        t    = prod[40:8];
        return (|t[32:16]) ? 16'hFFFF : t[15:0];
    endfunction

    // Clamp a 35-bit two's complement value to the signed 32-bit range
    function automatic logic [31:0] sat_coord(input logic [34:0] v);
        logic [31:0] r;
        if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
            r = v[31:0];
        end else if (v[34]) begin
            r = COORD_MIN;
        end else begin
            r = COORD_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/sqvg_front.sv =====
// Front end: configuration registers, request classification and the vertex slot counter.
// Depends on sqvg_pkg; feeds sprite entries into sqvg_fifo.
module sqvg_front #(
    parameter int unsigned VERTEX_CAPACITY = sqvg_pkg::VERTEX_CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_wdata,
    input  logic                i_accept,
    input  logic                i_cmd,
    input  logic [3:0]          i_flags,
    input  logic [31:0]         i_anchor_x,
    input  logic [31:0]         i_anchor_y,
    input  logic [31:0]         i_origin_x,
    input  logic [31:0]         i_origin_y,
    input  logic [31:0]         i_scale_xy,
    input  logic [15:0]         i_src_x,
    input  logic [15:0]         i_src_y,
    input  logic [15:0]         i_src_w,
    input  logic [15:0]         i_src_h,
    input  logic [31:0]         i_tint,
    output logic                o_wr_en,
    output sqvg_pkg::t_sprite   o_sprite,
    output sqvg_pkg::t_tex_cfg  o_tex_cfg
);
    import sqvg_pkg::*;

    localparam logic [15:0] SLOT_LIMIT = 16'(VERTEX_CAPACITY - VERTS_PER_SPRITE);

    logic        r_tex_present;
    logic [23:0] r_recip_w;
    logic [23:0] r_recip_h;
    logic [15:0] r_counter;
    logic [15:0] n_counter;
    logic [16:0] adv_sum;
    logic        is_sprite;
    logic        batch_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_present <= 1'b0;
            r_recip_w     <= 24'd262144;
            r_recip_h     <= 24'd262144;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TEX_PRESENT: r_tex_present <= i_cfg_wdata[0];
                CFG_RECIP_W:     r_recip_w     <= i_cfg_wdata;
                CFG_RECIP_H:     r_recip_h     <= i_cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign adv_sum   = {1'b0, r_counter} + 17'(VERTS_PER_SPRITE);
    assign is_sprite = (i_cmd == CMD_SPRITE) && i_flags[FLAG_VISIBLE];
    assign batch_ok  = r_tex_present && (r_counter <= SLOT_LIMIT);

    always_comb begin
        n_counter = r_counter;
        if (i_accept) begin
            if (i_cmd == CMD_BEGIN) begin
                n_counter = '0;
            end else if (is_sprite) begin
                n_counter = adv_sum[16] ? 16'hFFFF : adv_sum[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else begin
            r_counter <= n_counter;
        end
    end

    assign o_wr_en = i_accept && is_sprite && batch_ok;

    assign o_sprite.centered = i_flags[FLAG_CENTERED];
    assign o_sprite.flip_h   = i_flags[FLAG_FLIP_H];
    assign o_sprite.flip_v   = i_flags[FLAG_FLIP_V];
    assign o_sprite.anchor_x = i_anchor_x;
    assign o_sprite.anchor_y = i_anchor_y;
    assign o_sprite.origin_x = i_origin_x;
    assign o_sprite.origin_y = i_origin_y;
    assign o_sprite.scale_x  = i_scale_xy[31:16];
    assign o_sprite.scale_y  = i_scale_xy[15:0];
    assign o_sprite.src_x    = i_src_x;
    assign o_sprite.src_y    = i_src_y;
    assign o_sprite.src_w    = i_src_w;
    assign o_sprite.src_h    = i_src_h;
    assign o_sprite.tint     = i_tint;
    assign o_sprite.slot     = r_counter;

    assign o_tex_cfg.recip_w = r_recip_w;
    assign o_tex_cfg.recip_h = r_recip_h;

endmodule

// ===== rtl/sqvg_fifo.sv =====
// Short sprite queue between the front end and the vertex back end.
// Depends on sqvg_pkg for the entry type.
module sqvg_fifo #(
    parameter int unsigned DEPTH = sqvg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  sqvg_pkg::t_sprite  i_wr_data,
    input  logic               i_rd_en,
    output sqvg_pkg::t_sprite  o_rd_data,
    output logic               o_full,
    output logic               o_empty
);
    import sqvg_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_sprite          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr_en && !o_full;
    assign do_rd   = i_rd_en && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];

endmodule

// ===== rtl/sqvg_back.sv =====
// Back end: size and texture products, corner base, six-step vertex emit and output register.
// Depends on sqvg_pkg; pulls sprite entries from sqvg_fifo.
module sqvg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sqvg_pkg::t_tex_cfg  i_tex_cfg,
    input  logic                i_q_empty,
    input  sqvg_pkg::t_sprite   i_q_data,
    output logic                o_q_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output sqvg_pkg::t_vertex   o_vertex
);
    import sqvg_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'(VERTS_PER_SPRITE - 1);

    // Product stage
    logic        r_s1_valid;
    logic [31:0] r_s1_w;
    logic [31:0] r_s1_h;
    logic [15:0] r_s1_u0, r_s1_u1, r_s1_v0, r_s1_v1;
    t_sprite     r_s1_spr;

    // Emit stage
    logic        r_s2_valid;
    logic [2:0]  r_s2_step;
    logic [34:0] r_s2_x;
    logic [34:0] r_s2_y;
    logic [31:0] r_s2_w;
    logic [31:0] r_s2_h;
    logic [15:0] r_s2_u0, r_s2_u1, r_s2_v0, r_s2_v1;
    logic        r_s2_flip_h, r_s2_flip_v;
    logic [31:0] r_s2_tint;
    logic [15:0] r_s2_slot;

    logic        r_out_valid;
    t_vertex     r_out;

    logic        emit;
    logic        s2_load;
    logic        s1_load;
    logic [34:0] base_x;
    logic [34:0] base_y;
    logic [34:0] org_x;
    logic [34:0] org_y;
    logic [1:0]  corner;
    logic        c_right;
    logic        c_down;
    logic [34:0] vx;
    logic [34:0] vy;

    assign emit    = r_s2_valid && (!r_out_valid || i_pop);
    assign s2_load = !r_s2_valid || (emit && (r_s2_step == LAST_STEP));
    assign s1_load = !r_s1_valid || s2_load;
    assign o_q_rd  = s1_load && !i_q_empty;

    // Products: scaled size and texture edges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_s1_w   <= 32'(i_q_data.src_w) * 32'(i_q_data.scale_x);
            r_s1_h   <= 32'(i_q_data.src_h) * 32'(i_q_data.scale_y);
            r_s1_u0  <= tex_coord({1'b0, i_q_data.src_x}, i_tex_cfg.recip_w);
            r_s1_u1  <= tex_coord(17'(i_q_data.src_x) + 17'(i_q_data.src_w),
                                  i_tex_cfg.recip_w);
            r_s1_v0  <= tex_coord({1'b0, i_q_data.src_y}, i_tex_cfg.recip_h);
            r_s1_v1  <= tex_coord(17'(i_q_data.src_y) + 17'(i_q_data.src_h),
                                  i_tex_cfg.recip_h);
            r_s1_spr <= i_q_data;
        end
    end

    // Top-left corner before flips: anchor minus origin (half size when centered)
    assign org_x  = r_s1_spr.centered ? {4'b0, r_s1_w[31:1]}
                                      : {{3{r_s1_spr.origin_x[31]}}, r_s1_spr.origin_x};
    assign org_y  = r_s1_spr.centered ? {4'b0, r_s1_h[31:1]}
                                      : {{3{r_s1_spr.origin_y[31]}}, r_s1_spr.origin_y};
    assign base_x = {{3{r_s1_spr.anchor_x[31]}}, r_s1_spr.anchor_x} - org_x;
    assign base_y = {{3{r_s1_spr.anchor_y[31]}}, r_s1_spr.anchor_y} - org_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_step  <= '0;
        end else if (s2_load) begin
            r_s2_valid <= r_s1_valid;
            r_s2_step  <= '0;
        end else if (emit) begin
            r_s2_step  <= r_s2_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r_s1_valid) begin
            r_s2_x      <= base_x;
            r_s2_y      <= base_y;
            r_s2_w      <= r_s1_w;
            r_s2_h      <= r_s1_h;
            r_s2_u0     <= r_s1_u0;
            r_s2_u1     <= r_s1_u1;
            r_s2_v0     <= r_s1_v0;
            r_s2_v1     <= r_s1_v1;
            r_s2_flip_h <= r_s1_spr.flip_h;
            r_s2_flip_v <= r_s1_spr.flip_v;
            r_s2_tint   <= r_s1_spr.tint;
            r_s2_slot   <= r_s1_spr.slot;
        end
    end

    // Flips move positions only; texture coordinates stay with their corner
    assign corner  = corner_of(r_s2_step);
    assign c_right = (corner == CORNER_BR) || (corner == CORNER_TR);
    assign c_down  = (corner == CORNER_BL) || (corner == CORNER_BR);
    assign vx      = r_s2_x + ((c_right ^ r_s2_flip_h) ? {3'b0, r_s2_w} : 35'd0);
    assign vy      = r_s2_y + ((c_down  ^ r_s2_flip_v) ? {3'b0, r_s2_h} : 35'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.vert_x      <= sat_coord(vx);
            r_out.vert_y      <= sat_coord(vy);
            r_out.tex_u       <= c_right ? r_s2_u1 : r_s2_u0;
            r_out.tex_v       <= c_down ? r_s2_v1 : r_s2_v0;
            r_out.vert_color  <= r_s2_tint;
            r_out.vertex_slot <= r_s2_slot + 16'(r_s2_step);
            r_out.last        <= (r_s2_step == LAST_STEP);
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_vertex = r_out;

endmodule

// ===== rtl/sprite_quad_vertex_generator_top.sv =====
// Sprite quad vertex generator: expands each queued sprite request into six vertices.
// Each sprite passes the queue, product stage, emit stage and output register; vertices
// leave one per cycle while pop keeps up. The single emit stage steps through the six
// vertices of a sprite before the next; begin, hidden and dropped requests skip the queue.
// Reset (synchronous, i_rst_n low): slot counter, queue and pipeline cleared,
// texture_present cleared, both reciprocals set to 262144.
module sprite_quad_vertex_generator_top #(
    parameter int unsigned VERTEX_CAPACITY = sqvg_pkg::VERTEX_CAPACITY_DEF,
    parameter int unsigned QUEUE_DEPTH     = sqvg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_wdata,
    // Request side
    input  logic         push,
    output logic         full,
    input  logic         i_cmd,
    input  logic [3:0]   i_flags,
    input  logic [31:0]  i_anchor_x,
    input  logic [31:0]  i_anchor_y,
    input  logic [31:0]  i_origin_x,
    input  logic [31:0]  i_origin_y,
    input  logic [31:0]  i_scale_xy,
    input  logic [15:0]  i_src_x,
    input  logic [15:0]  i_src_y,
    input  logic [15:0]  i_src_w,
    input  logic [15:0]  i_src_h,
    input  logic [31:0]  i_tint,
    // Vertex side
    output logic         empty,
    input  logic         pop,
    output logic [31:0]  o_vert_x,
    output logic [31:0]  o_vert_y,
    output logic [15:0]  o_tex_u,
    output logic [15:0]  o_tex_v,
    output logic [31:0]  o_vert_color,
    output logic [15:0]  o_vertex_slot,
    output logic         o_last
);
    import sqvg_pkg::*;

    logic     accept;
    logic     q_wr_en;
    logic     q_rd_en;
    logic     q_full;
    logic     q_empty;
    t_sprite  q_wr_data;
    t_sprite  q_rd_data;
    t_tex_cfg tex_cfg;
    t_vertex  vertex;

    // Hold every request while the queue is full, drawn or not, to keep the counter in order
    assign full   = q_full;
    assign accept = push && !q_full;

    // Classify the request and advance the slot counter
    sqvg_front #(
        .VERTEX_CAPACITY(VERTEX_CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .i_flags     (i_flags),
        .i_anchor_x  (i_anchor_x),
        .i_anchor_y  (i_anchor_y),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_scale_xy  (i_scale_xy),
        .i_src_x     (i_src_x),
        .i_src_y     (i_src_y),
        .i_src_w     (i_src_w),
        .i_src_h     (i_src_h),
        .i_tint      (i_tint),
        .o_wr_en     (q_wr_en),
        .o_sprite    (q_wr_data),
        .o_tex_cfg   (tex_cfg)
    );

    // Decouple classification from vertex emission
    sqvg_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr_en),
        .i_wr_data (q_wr_data),
        .i_rd_en   (q_rd_en),
        .o_rd_data (q_rd_data),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    // Compute corners and emit six vertices per sprite
    sqvg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tex_cfg (tex_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_rd_data),
        .o_q_rd    (q_rd_en),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_vertex  (vertex)
    );

    assign o_vert_x      = vertex.vert_x;
    assign o_vert_y      = vertex.vert_y;
    assign o_tex_u       = vertex.tex_u;
    assign o_tex_v       = vertex.tex_v;
    assign o_vert_color  = vertex.vert_color;
    assign o_vertex_slot = vertex.vertex_slot;
    assign o_last        = vertex.last;

endmodule

// ===== tb/sv/sqvg_vertex_checker.sv =====
// Vertex checker for the sprite quad vertex generator: watches the request, register
// and vertex channels, predicts six vertices per drawn sprite and compares them in order.
// Depends on sqvg_pkg for register indexes, command codes, flag positions and t_vertex.
`timescale 1ns / 100ps

module sqvg_vertex_checker #(
    parameter int unsigned VERTEX_CAPACITY = sqvg_pkg::VERTEX_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_cmd,
    input  logic [3:0]  i_flags,
    input  logic [31:0] i_anchor_x,
    input  logic [31:0] i_anchor_y,
    input  logic [31:0] i_origin_x,
    input  logic [31:0] i_origin_y,
    input  logic [31:0] i_scale_xy,
    input  logic [15:0] i_src_x,
    input  logic [15:0] i_src_y,
    input  logic [15:0] i_src_w,
    input  logic [15:0] i_src_h,
    input  logic [31:0] i_tint,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [31:0] i_vert_x,
    input  logic [31:0] i_vert_y,
    input  logic [15:0] i_tex_u,
    input  logic [15:0] i_tex_v,
    input  logic [31:0] i_vert_color,
    input  logic [15:0] i_vertex_slot,
    input  logic        i_last,
    output int          o_err_count,
    output int          o_pending_count
);
    import sqvg_pkg::*;

    localparam logic [23:0] RECIP_RESET = 24'd262144;
    localparam int          MAX_REPORTS = 10;
    localparam longint      COORD_HI    = 64'sd2147483647;
    localparam longint      COORD_LO    = -64'sd2147483648;

    // Corner visited by each of the six vertices (two triangles)
    localparam logic [1:0] TRI_ORDER [6] = '{CORNER_TL, CORNER_BL, CORNER_BR,
                                             CORNER_TR, CORNER_BR, CORNER_TL};

    t_vertex     expected_verts[$];
    logic        tex_bound;
    logic [23:0] recip_u;
    logic [23:0] recip_v;
    logic [15:0] slot_count;
    int          failures = 0;

    function automatic logic [31:0] clamp_coord(input longint v);
        if (v > COORD_HI) return COORD_MAX;
        if (v < COORD_LO) return COORD_MIN;
        return v[31:0];
    endfunction

    function automatic logic [15:0] texel_to_uv(input logic [16:0] texel,
                                                input logic [23:0] recip);
        logic [63:0] scaled;
        scaled = ({47'd0, texel} * {40'd0, recip}) >> 8;
        return (scaled > 64'hFFFF) ? 16'hFFFF : scaled[15:0];
    endfunction

    function automatic logic [15:0] bump_slot(input logic [15:0] s);
        logic [16:0] n;
        n = {1'b0, s} + 17'(VERTS_PER_SPRITE);
        return n[16] ? 16'hFFFF : n[15:0];
    endfunction

    // Work out the vertices of one accepted request and update the slot counter
    task automatic predict_request();
        longint      w, h, ox, oy, bx, by, t;
        longint      cx[4];
        longint      cy[4];
        logic [15:0] cu[4];
        logic [15:0] cv[4];
        t_vertex     v;
        logic [1:0]  c;
        if (i_cmd == CMD_BEGIN) begin
            slot_count = '0;
            return;
        end
        if (!i_flags[FLAG_VISIBLE]) return;
        if (!tex_bound ||
            int'(slot_count) > int'(VERTEX_CAPACITY) - int'(VERTS_PER_SPRITE)) begin
            slot_count = bump_slot(slot_count);
            return;
        end
        w = longint'({48'd0, i_src_w}) * longint'({48'd0, i_scale_xy[31:16]});
        h = longint'({48'd0, i_src_h}) * longint'({48'd0, i_scale_xy[15:0]});
        if (i_flags[FLAG_CENTERED]) begin
            ox = w >>> 1;
            oy = h >>> 1;
        end else begin
            ox = longint'($signed(i_origin_x));
            oy = longint'($signed(i_origin_y));
        end
        bx = longint'($signed(i_anchor_x)) - ox;
        by = longint'($signed(i_anchor_y)) - oy;
        cx[CORNER_TL] = bx;     cy[CORNER_TL] = by;
        cx[CORNER_BL] = bx;     cy[CORNER_BL] = by + h;
        cx[CORNER_BR] = bx + w; cy[CORNER_BR] = by + h;
        cx[CORNER_TR] = bx + w; cy[CORNER_TR] = by;
        // Flips move positions only; texture coordinates stay with their corners
        if (i_flags[FLAG_FLIP_H]) begin
            t = cx[CORNER_TL]; cx[CORNER_TL] = cx[CORNER_TR]; cx[CORNER_TR] = t;
            t = cy[CORNER_TL]; cy[CORNER_TL] = cy[CORNER_TR]; cy[CORNER_TR] = t;
            t = cx[CORNER_BL]; cx[CORNER_BL] = cx[CORNER_BR]; cx[CORNER_BR] = t;
            t = cy[CORNER_BL]; cy[CORNER_BL] = cy[CORNER_BR]; cy[CORNER_BR] = t;
        end
        if (i_flags[FLAG_FLIP_V]) begin
            t = cx[CORNER_TL]; cx[CORNER_TL] = cx[CORNER_BL]; cx[CORNER_BL] = t;
            t = cy[CORNER_TL]; cy[CORNER_TL] = cy[CORNER_BL]; cy[CORNER_BL] = t;
            t = cx[CORNER_TR]; cx[CORNER_TR] = cx[CORNER_BR]; cx[CORNER_BR] = t;
            t = cy[CORNER_TR]; cy[CORNER_TR] = cy[CORNER_BR]; cy[CORNER_BR] = t;
        end
        cu[CORNER_TL] = texel_to_uv({1'b0, i_src_x}, recip_u);
        cu[CORNER_BL] = cu[CORNER_TL];
        cu[CORNER_BR] = texel_to_uv({1'b0, i_src_x} + {1'b0, i_src_w}, recip_u);
        cu[CORNER_TR] = cu[CORNER_BR];
        cv[CORNER_TL] = texel_to_uv({1'b0, i_src_y}, recip_v);
        cv[CORNER_TR] = cv[CORNER_TL];
        cv[CORNER_BL] = texel_to_uv({1'b0, i_src_y} + {1'b0, i_src_h}, recip_v);
        cv[CORNER_BR] = cv[CORNER_BL];
        for (int k = 0; k < 6; k++) begin
            c             = TRI_ORDER[k];
            v.vert_x      = clamp_coord(cx[c]);
            v.vert_y      = clamp_coord(cy[c]);
            v.tex_u       = cu[c];
            v.tex_v       = cv[c];
            v.vert_color  = i_tint;
            v.vertex_slot = slot_count + 16'(k);
            v.last        = (k == 5);
            expected_verts.push_back(v);
        end
        slot_count = bump_slot(slot_count);
    endtask

    always @(posedge i_clk) begin : watch
        t_vertex got;
        t_vertex want;
        if (!i_rst_n) begin
            expected_verts.delete();
            tex_bound  = 1'b0;
            recip_u    = RECIP_RESET;
            recip_v    = RECIP_RESET;
            slot_count = '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_TEX_PRESENT: tex_bound = i_cfg_wdata[0];
                    CFG_RECIP_W:     recip_u   = i_cfg_wdata;
                    CFG_RECIP_H:     recip_v   = i_cfg_wdata;
                    default:         ;
                endcase
            end
            if (i_pop && !i_empty) begin
                got = '{vert_x: i_vert_x, vert_y: i_vert_y, tex_u: i_tex_u,
                        tex_v: i_tex_v, vert_color: i_vert_color,
                        vertex_slot: i_vertex_slot, last: i_last};
                if (expected_verts.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("unexpected vertex: x=%h y=%h slot=%0d last=%b",
                                 got.vert_x, got.vert_y, got.vertex_slot, got.last);
                end else begin
                    want = expected_verts.pop_front();
                    if (got.vert_x !== want.vert_x || got.vert_y !== want.vert_y ||
                        got.tex_u !== want.tex_u || got.tex_v !== want.tex_v ||
                        got.vert_color !== want.vert_color ||
                        got.vertex_slot !== want.vertex_slot ||
                        got.last !== want.last) begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display({"vertex mismatch: expected x=%h y=%h u=%h v=%h ",
                                      "c=%h slot=%0d last=%b, got x=%h y=%h u=%h v=%h ",
                                      "c=%h slot=%0d last=%b"},
                                     want.vert_x, want.vert_y, want.tex_u, want.tex_v,
                                     want.vert_color, want.vertex_slot, want.last,
                                     got.vert_x, got.vert_y, got.tex_u, got.tex_v,
                                     got.vert_color, got.vertex_slot, got.last);
                    end
                end
            end
            if (i_push && !i_full) predict_request();
        end
        o_pending_count <= expected_verts.size();
        o_err_count     <= failures;
    end

endmodule

// ===== tb/sv/tb_sprite_quad_vertex_generator_top.sv =====
// Testbench top of the sprite quad vertex generator: clock, reset, request and register
// stimulus, vertex pop pacing and the verdict. Depends on sqvg_pkg and sqvg_vertex_checker.
`timescale 1ns / 100ps

module tb_sprite_quad_vertex_generator_top;
    import sqvg_pkg::*;

    localparam int unsigned VCAP = VERTEX_CAPACITY_DEF;

    // Index past the last register; writes to it must change nothing
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // Slowest correct run: ~350 requests of up to six vertices each popped at a 10% pace,
    // sender gaps between bursts and one long hold-off. The limit allows far more than that.
    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;     // margin after the last vertex drains
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 55;

    localparam logic [3:0] F_CENT = 4'(1 << FLAG_CENTERED);
    localparam logic [3:0] F_FH   = 4'(1 << FLAG_FLIP_H);
    localparam logic [3:0] F_FV   = 4'(1 << FLAG_FLIP_V);
    localparam logic [3:0] F_VIS  = 4'(1 << FLAG_VISIBLE);

    typedef struct {
        logic        cmd;
        logic [3:0]  flags;
        logic [31:0] anchor_x;
        logic [31:0] anchor_y;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] scale_xy;
        logic [15:0] src_x;
        logic [15:0] src_y;
        logic [15:0] src_w;
        logic [15:0] src_h;
        logic [31:0] tint;
    } t_sprite_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_wdata;
    logic        push;
    logic        full;
    logic        i_cmd;
    logic [3:0]  i_flags;
    logic [31:0] i_anchor_x;
    logic [31:0] i_anchor_y;
    logic [31:0] i_origin_x;
    logic [31:0] i_origin_y;
    logic [31:0] i_scale_xy;
    logic [15:0] i_src_x;
    logic [15:0] i_src_y;
    logic [15:0] i_src_w;
    logic [15:0] i_src_h;
    logic [31:0] i_tint;
    logic        empty;
    logic        pop;
    logic [31:0] o_vert_x;
    logic [31:0] o_vert_y;
    logic [15:0] o_tex_u;
    logic [15:0] o_tex_v;
    logic [31:0] o_vert_color;
    logic [15:0] o_vertex_slot;
    logic        o_last;

    int   err_count;
    int   pending_count;
    int   burst_left = 0;
    logic steady     = 1'b0;   // sender offers back to back when set
    logic hold_request = 1'b0; // asks the receiver for one long hold-off

    sprite_quad_vertex_generator_top #(
        .VERTEX_CAPACITY(VCAP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_flags      (i_flags),
        .i_anchor_x   (i_anchor_x),
        .i_anchor_y   (i_anchor_y),
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_scale_xy   (i_scale_xy),
        .i_src_x      (i_src_x),
        .i_src_y      (i_src_y),
        .i_src_w      (i_src_w),
        .i_src_h      (i_src_h),
        .i_tint       (i_tint),
        .empty        (empty),
        .pop          (pop),
        .o_vert_x     (o_vert_x),
        .o_vert_y     (o_vert_y),
        .o_tex_u      (o_tex_u),
        .o_tex_v      (o_tex_v),
        .o_vert_color (o_vert_color),
        .o_vertex_slot(o_vertex_slot),
        .o_last       (o_last)
    );

    sqvg_vertex_checker #(
        .VERTEX_CAPACITY(VCAP)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (push),
        .i_full         (full),
        .i_cmd          (i_cmd),
        .i_flags        (i_flags),
        .i_anchor_x     (i_anchor_x),
        .i_anchor_y     (i_anchor_y),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_scale_xy     (i_scale_xy),
        .i_src_x        (i_src_x),
        .i_src_y        (i_src_y),
        .i_src_w        (i_src_w),
        .i_src_h        (i_src_h),
        .i_tint         (i_tint),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_vert_x       (o_vert_x),
        .i_vert_y       (o_vert_y),
        .i_tex_u        (o_tex_u),
        .i_tex_v        (o_tex_v),
        .i_vert_color   (o_vert_color),
        .i_vertex_slot  (o_vertex_slot),
        .i_last         (o_last),
        .o_err_count    (err_count),
        .o_pending_count(pending_count)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the vertex stream never drains
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: pop at a random pace that changes from span to span, from every cycle
    // down to one in ten; on a hold request, keep pop low for a long stretch.
    initial begin : receiver
        int pace;
        int span;
        pop  = 1'b0;
        pace = 100;
        span = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            if (span == 0) begin
                span = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0:       pace = 100;
                    1:       pace = 70;
                    2:       pace = 35;
                    default: pace = 10;
                endcase
            end
            span--;
            pop = ($urandom_range(1, 100) <= pace);
        end
    end

    function automatic t_sprite_req make_sprite(
        input logic [3:0]  flags,
        input logic [31:0] ax, ay, ox, oy, scale,
        input logic [15:0] sx, sy, sw, sh,
        input logic [31:0] tint
    );
        t_sprite_req r;
        r = '{cmd: CMD_SPRITE, flags: flags, anchor_x: ax, anchor_y: ay,
              origin_x: ox, origin_y: oy, scale_xy: scale, src_x: sx, src_y: sy,
              src_w: sw, src_h: sh, tint: tint};
        return r;
    endfunction

    // Begin request: every other field is ignored, so fill it with all ones
    function automatic t_sprite_req begin_request();
        t_sprite_req r;
        r = make_sprite(4'hF, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        r.cmd = CMD_BEGIN;
        return r;
    endfunction

    // Q19.12 value within about +-1024 pixels
    function automatic logic [31:0] near_coord();
        return 32'($urandom_range(0, 32'h007F_FFFF)) - 32'h0040_0000;
    endfunction

    // Mostly screen-sized sprites with some begins and hidden ones; one in eight
    // uses full-width values everywhere so every bit toggles and coordinates overflow.
    function automatic t_sprite_req random_request();
        t_sprite_req r;
        logic        wide;
        wide    = ($urandom_range(0, 7) == 0);
        r.cmd   = ($urandom_range(0, 99) < 4) ? CMD_BEGIN : CMD_SPRITE;
        r.flags = 4'($urandom());
        if ($urandom_range(0, 99) < 85) r.flags[FLAG_VISIBLE] = 1'b1;
        if (wide) begin
            r.anchor_x = $urandom();
            r.anchor_y = $urandom();
            r.origin_x = $urandom();
            r.origin_y = $urandom();
            r.scale_xy = $urandom();
            r.src_x    = 16'($urandom());
            r.src_y    = 16'($urandom());
            r.src_w    = 16'($urandom());
            r.src_h    = 16'($urandom());
        end else begin
            r.anchor_x = near_coord();
            r.anchor_y = near_coord();
            r.origin_x = near_coord();
            r.origin_y = near_coord();
            r.scale_xy = {16'($urandom_range(0, 16'h3000)), 16'($urandom_range(0, 16'h3000))};
            r.src_x    = 16'($urandom_range(0, 1023));
            r.src_y    = 16'($urandom_range(0, 1023));
            r.src_w    = 16'($urandom_range(0, 255));
            r.src_h    = 16'($urandom_range(0, 255));
        end
        r.tint = $urandom();
        return r;
    endfunction

    // Offer one request and hold it until accepted. Enter and leave at a falling edge.
    // Push stays high into the next offer; only a gap or wait_drained lowers it.
    task automatic offer_request(input t_sprite_req r);
        if (!steady) begin
            if (burst_left == 0) begin
                push = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        i_cmd      = r.cmd;
        i_flags    = r.flags;
        i_anchor_x = r.anchor_x;
        i_anchor_y = r.anchor_y;
        i_origin_x = r.origin_x;
        i_origin_y = r.origin_y;
        i_scale_xy = r.scale_xy;
        i_src_x    = r.src_x;
        i_src_y    = r.src_y;
        i_src_w    = r.src_w;
        i_src_h    = r.src_h;
        i_tint     = r.tint;
        push       = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic program_texture(input logic present, input logic [23:0] rw,
                                   input logic [23:0] rh);
        write_reg(CFG_TEX_PRESENT, {23'd0, present});
        write_reg(CFG_RECIP_W, rw);
        write_reg(CFG_RECIP_H, rh);
    endtask

    // Drop push, wait for every expected vertex, then give the pipeline a margin
    // before the registers change.
    task automatic wait_drained();
        push = 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [23:0] rw;
        logic [23:0] rh;
        logic        present;

        // Drive every input known from time zero while reset is held low
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_TEX_PRESENT;
        i_cfg_wdata = '0;
        push        = 1'b0;
        i_cmd       = CMD_SPRITE;
        i_flags     = '0;
        i_anchor_x  = '0;
        i_anchor_y  = '0;
        i_origin_x  = '0;
        i_origin_y  = '0;
        i_scale_xy  = '0;
        i_src_x     = '0;
        i_src_y     = '0;
        i_src_w     = '0;
        i_src_h     = '0;
        i_tint      = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset leaves no texture bound: a visible sprite only advances the counter
        offer_request(make_sprite(F_VIS, 32'h0001_0000, 32'h0001_0000, '0, '0,
                                  32'h1000_1000, 16'd0, 16'd0, 16'd8, 16'd8, 32'h1234_5678));
        wait_drained();
        program_texture(1'b1, 24'd262144, 24'd131072);
        write_reg(CFG_SPARE, 24'hFFFFFF);  // out of range, must be ignored

        // Directed requests: counter carried over from the dropped sprite, then a begin
        offer_request(make_sprite(F_VIS, 32'(100 << 12), 32'(50 << 12), 32'(8 << 12),
                                  32'(4 << 12), 32'h1000_1000, 16'd0, 16'd0, 16'd16,
                                  16'd16, 32'hFF00_FF00));
        offer_request(begin_request());
        offer_request(make_sprite(F_VIS | F_CENT, 32'(200 << 12), 32'(120 << 12), '0, '0,
                                  32'h2000_1800, 16'd16, 16'd32, 16'd24, 16'd10,
                                  32'h00FF_00FF));
        offer_request(make_sprite(F_VIS | F_FH, 32'(10 << 12), 32'(20 << 12), 32'(2 << 12),
                                  32'(3 << 12), 32'h1000_1000, 16'd4, 16'd4, 16'd12,
                                  16'd20, 32'h0F0F_0F0F));
        offer_request(make_sprite(F_VIS | F_FV, 32'(10 << 12), 32'(20 << 12), 32'(2 << 12),
                                  32'(3 << 12), 32'h1000_1000, 16'd4, 16'd4, 16'd12,
                                  16'd20, 32'hF0F0_F0F0));
        offer_request(make_sprite(F_VIS | F_FH | F_FV, 32'(64 << 12), 32'(64 << 12),
                                  32'(32 << 12), 32'(16 << 12), 32'h0800_3000, 16'd100,
                                  16'd200, 16'd48, 16'd9, 32'hAAAA_5555));
        // Odd scaled size: the centered origin rounds toward zero
        offer_request(make_sprite(4'hF, 32'd0, 32'd0, '0, '0, 32'h0001_0001, 16'd1,
                                  16'd1, 16'd3, 16'd5, 32'h5555_AAAA));
        // Hidden sprite: no vertices, counter unchanged
        offer_request(make_sprite(F_CENT | F_FH | F_FV, 32'd0, 32'd0, '0, '0,
                                  32'h1000_1000, 16'd0, 16'd0, 16'd8, 16'd8, 32'hDEAD_BEEF));
        // Zero-sized source rectangle
        offer_request(make_sprite(F_VIS, 32'(5 << 12), 32'(7 << 12), '0, '0, 32'h1000_1000,
                                  16'd9, 16'd9, 16'd0, 16'd0, 32'h0000_0001));
        // Coordinate overflow toward the positive limit
        offer_request(make_sprite(F_VIS, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h8000_0000, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'hFFFF,
                                  16'hFFFF, 32'h8000_0000));
        // Coordinate overflow toward the negative limit
        offer_request(make_sprite(F_VIS | F_FH, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h0000_0000, 16'd0, 16'd0, 16'hFFFF,
                                  16'hFFFF, 32'h7FFF_FFFF));
        // Largest size, centered around zero
        offer_request(make_sprite(F_VIS | F_CENT, 32'd0, 32'd0, '0, '0, 32'hFFFF_FFFF,
                                  16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'h0123_4567));
        // Texture coordinates beyond one saturate
        offer_request(make_sprite(F_VIS | F_FV, 32'd0, 32'd0, 32'hFFFF_F000, 32'hFFFF_F000,
                                  32'h1000_1000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  32'h0000_0000));
        offer_request(make_sprite(4'hF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001,
                                  32'hFFFF_FFFF, 32'h0001_FFFF, 16'h8000, 16'h7FFF,
                                  16'h7FFF, 16'h8000, 32'hFFFF_FFFF));
        offer_request(begin_request());
        offer_request(make_sprite(F_VIS, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                                  32'h0000_0000, 32'h0000_0000, 16'd0, 16'd0, 16'd0,
                                  16'd0, 32'h0000_0000));
        wait_drained();

        // Random phases, each under its own texture setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            present = 1'b1;
            case (ph)
                0: begin rw = 24'd262144; rh = 24'd262144; end
                1: begin rw = 24'hFFFFFF; rh = 24'hFFFFFF; end
                2: begin rw = 24'd0;      rh = 24'd0;      end
                3: begin rw = 24'($urandom()); rh = 24'($urandom()); end
                4: begin
                    present = 1'b0;
                    rw = 24'($urandom());
                    rh = 24'($urandom());
                end
                default: begin
                    rw = 24'($urandom_range(1, 24'h4000));
                    rh = 24'($urandom_range(1, 24'h4000));
                end
            endcase
            program_texture(present, rw, rh);
            // In one phase stall the receiver for a long stretch while requests keep
            // coming, so the queue fills and full holds the sender back
            steady = (ph == 1);
            if (ph == 1) hold_request = 1'b1;
            repeat (PHASE_ITEMS) offer_request(random_request());
            wait_drained();
        end

        if (err_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sprite_quad_vertex_generator_top.f =====
rtl/sqvg_pkg.sv
rtl/sqvg_front.sv
rtl/sqvg_fifo.sv
rtl/sqvg_back.sv
rtl/sprite_quad_vertex_generator_top.sv
tb/sv/sqvg_vertex_checker.sv
tb/sv/tb_sprite_quad_vertex_generator_top.sv
